// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge outside reset
`define PSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be seen outside reset
`define PSD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ===== hdl/psd_pkg.sv =====
// shared types, constants and functions of the priority scheduler
package psd_pkg;

    localparam int NUM_PRIOS = 32;
    localparam int TICK_BITS = 16;
    localparam int IDX_W     = $clog2(NUM_PRIOS);
    localparam int PRIO_W    = 6;
    localparam int DELAY_W   = 16;
    localparam int TYPE_W    = 2;
    localparam int STAT_W    = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam logic [31:0] TICK_MAX = 32'((64'd1 << TICK_BITS) - 64'd1);

    typedef enum logic [TYPE_W-1:0] {
        REQ_TICK    = 2'd0,
        REQ_DELAY   = 2'd1,
        REQ_START   = 2'd2,
        REQ_RESCHED = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_IDLE  = 2'd1,
        ST_TAKEN = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic tick_rd;
        logic exec;
        logic sched;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic out_busy;
    } t_dp_stat;

    // highest set bit as priority number, 0 when none is set
    function automatic logic [PRIO_W-1:0] highest_ready(input logic [NUM_PRIOS-1:0] m);
        logic [PRIO_W-1:0] r;
        r = '0;
        for (int p = 0; p < NUM_PRIOS; p++) begin
            if (m[p]) begin
                r = PRIO_W'(p + 1);
            end
        end
        return r;
    endfunction

    // clamp a requested delay to the counter range
    function automatic logic [TICK_BITS-1:0] sat_ticks(input logic [DELAY_W-1:0] d);
        logic [31:0] w;
        w = 32'(d);
        if (w > TICK_MAX) begin
            w = TICK_MAX;
        end
        return w[TICK_BITS-1:0];
    endfunction

endpackage

// ===== hdl/psd_ctrl.sv =====
// controller state machine of the priority scheduler
module psd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  psd_pkg::t_req    i_req_type,
    output logic             o_in_ready,
    input  psd_pkg::t_dp_stat i_stat,
    output psd_pkg::t_dp_cmd  o_cmd
);
    import psd_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_TICK_RD = 6'b000010,
        S_TICK_WB = 6'b000100,
        S_EXEC    = 6'b001000,
        S_SCHED   = 6'b010000,
        S_FINISH  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_req_type == REQ_TICK) ? S_TICK_RD : S_EXEC;
                end
            end
            S_TICK_RD: begin
                o_cmd.tick_rd = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_TICK_WB;
                end
            end
            // last count goes back to memory here
            S_TICK_WB: begin
                n_state = S_FINISH;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = S_SCHED;
            end
            S_SCHED: begin
                o_cmd.sched = 1'b1;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/psd_datapath.sv =====
// masks, tick counters, selection and result register of the scheduler
module psd_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  psd_pkg::t_dp_cmd           i_cmd,
    output psd_pkg::t_dp_stat          o_stat,
    input  logic [psd_pkg::TYPE_W-1:0]  i_req_type,
    input  logic [psd_pkg::DELAY_W-1:0] i_delay_ticks,
    input  logic [psd_pkg::PRIO_W-1:0]  i_thread_prio,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [psd_pkg::PRIO_W-1:0]  o_next_prio,
    output logic                       o_switch_request,
    output logic [psd_pkg::STAT_W-1:0]  o_status
);
    import psd_pkg::*;

    logic [TICK_BITS-1:0] r_ticks_mem [NUM_PRIOS];
    logic [TICK_BITS-1:0] r_rd_data;

    t_req                 r_req,        n_req;
    logic [DELAY_W-1:0]   r_delay,      n_delay;
    logic [PRIO_W-1:0]    r_prio,       n_prio;
    logic [NUM_PRIOS-1:0] r_ready,      n_ready;
    logic [NUM_PRIOS-1:0] r_blocked,    n_blocked;
    logic [NUM_PRIOS-1:0] r_registered, n_registered;
    logic [PRIO_W-1:0]    r_cur_prio,   n_cur_prio;
    logic                 r_cur_valid,  n_cur_valid;
    logic [IDX_W-1:0]     r_idx,        n_idx;
    logic [IDX_W-1:0]     r_wb_idx,     n_wb_idx;
    logic                 r_wb_vld,     n_wb_vld;
    logic                 r_do_sched,   n_do_sched;
    logic                 r_sw,         n_sw;
    t_status              r_status,     n_status;
    logic                 r_out_valid,  n_out_valid;
    logic [PRIO_W-1:0]    r_out_next,   n_out_next;
    logic                 r_out_sw,     n_out_sw;
    t_status              r_out_status, n_out_status;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [TICK_BITS-1:0] mem_wdata;
    logic [TICK_BITS-1:0] dec_ticks;
    logic [IDX_W-1:0]     cur_idx;
    logic [IDX_W-1:0]     start_idx;
    logic                 start_bad;
    logic [PRIO_W-1:0]    sel_prio;

    assign cur_idx   = IDX_W'(r_cur_prio - PRIO_W'(1));
    assign start_idx = IDX_W'(r_prio - PRIO_W'(1));
    assign dec_ticks = (r_rd_data == '0) ? '0 : r_rd_data - TICK_BITS'(1);
    assign sel_prio  = highest_ready(r_ready);
    assign start_bad = (r_prio == '0) || (r_prio > PRIO_W'(NUM_PRIOS))
                       || r_registered[start_idx];

    always_comb begin
        n_req        = r_req;
        n_delay      = r_delay;
        n_prio       = r_prio;
        n_ready      = r_ready;
        n_blocked    = r_blocked;
        n_registered = r_registered;
        n_cur_prio   = r_cur_prio;
        n_cur_valid  = r_cur_valid;
        n_idx        = r_idx;
        n_wb_idx     = r_wb_idx;
        n_wb_vld     = i_cmd.tick_rd;
        n_do_sched   = r_do_sched;
        n_sw         = r_sw;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_next   = r_out_next;
        n_out_sw     = r_out_sw;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_wb_idx;
        mem_wdata    = dec_ticks;

        if (i_cmd.load) begin
            n_req      = t_req'(i_req_type);
            n_delay    = i_delay_ticks;
            n_prio     = i_thread_prio;
            n_sw       = 1'b0;
            n_status   = ST_OK;
            n_do_sched = 1'b0;
            n_idx      = '0;
        end

        // tick walk: each count is read, then written back in the cycle after its read
        if (i_cmd.tick_rd) begin
            n_wb_idx = r_idx;
            n_idx    = r_idx + IDX_W'(1);
        end
        if (r_wb_vld && r_blocked[r_wb_idx]) begin
            mem_we = 1'b1;
            if (dec_ticks == '0) begin
                n_blocked[r_wb_idx] = 1'b0;
                n_ready[r_wb_idx]   = 1'b1;
            end
        end

        if (i_cmd.exec) begin
            case (r_req)
                REQ_DELAY: begin
                    if (!r_cur_valid || r_cur_prio == '0
                        || r_cur_prio > PRIO_W'(NUM_PRIOS)) begin
                        n_status = ST_IDLE;
                    end else if (r_delay == '0) begin
                        n_status = ST_ZERO;
                    end else begin
                        mem_we              = 1'b1;
                        mem_waddr           = cur_idx;
                        mem_wdata           = sat_ticks(r_delay);
                        n_ready[cur_idx]    = 1'b0;
                        n_blocked[cur_idx]  = 1'b1;
                        n_do_sched          = 1'b1;
                    end
                end
                REQ_START: begin
                    if (start_bad) begin
                        n_status = ST_TAKEN;
                    end else begin
                        n_registered[start_idx] = 1'b1;
                        n_ready[start_idx]      = 1'b1;
                    end
                end
                REQ_RESCHED: begin
                    n_do_sched = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.sched && r_do_sched) begin
            if (!r_cur_valid || sel_prio != r_cur_prio) begin
                n_sw        = 1'b1;
                n_cur_prio  = sel_prio;
                n_cur_valid = 1'b1;
            end
        end

        if (i_cmd.emit) begin
            n_out_valid  = 1'b1;
            n_out_next   = sel_prio;
            n_out_sw     = r_sw;
            n_out_status = r_status;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ticks_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.tick_rd) begin
            r_rd_data <= r_ticks_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_delay      <= n_delay;
        r_prio       <= n_prio;
        r_wb_idx     <= n_wb_idx;
        r_sw         <= n_sw;
        r_status     <= n_status;
        r_out_next   <= n_out_next;
        r_out_sw     <= n_out_sw;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready      <= '0;
            r_blocked    <= '0;
            r_registered <= '0;
            r_cur_prio   <= '0;
            r_cur_valid  <= 1'b0;
            r_idx        <= '0;
            r_wb_vld     <= 1'b0;
            r_do_sched   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_ready      <= n_ready;
            r_blocked    <= n_blocked;
            r_registered <= n_registered;
            r_cur_prio   <= n_cur_prio;
            r_cur_valid  <= n_cur_valid;
            r_idx        <= n_idx;
            r_wb_vld     <= n_wb_vld;
            r_do_sched   <= n_do_sched;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_stat.idx_last  = (r_idx == IDX_W'(NUM_PRIOS - 1));
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_next_prio      = r_out_next;
    assign o_switch_request = r_out_sw;
    assign o_status         = r_out_status;

endmodule

// ===== hdl/priority_scheduler_with_delays_core.sv =====
// top level of the bitmap priority scheduler with tick delays
//
// requests enter on the s_axis channel, one result per request leaves on m_axis.
// s_axis_tuser carries the request kind (tick, delay, start, reschedule);
// s_axis_tdata carries the delay count and the priority to start.
// m_axis_tdata returns the highest ready priority (0 = idle thread), the
// switch flag and a status code (ok, idle delayed, priority taken, zero delay).
// one request is worked on at a time. a tick walks all NUM_PRIOS counters
// through the count memory, one read and one write back per cycle, writes
// back the last count and then loads its result; delay, start and
// reschedule pass an execute and a schedule step before theirs is loaded.
// the next request is taken the cycle after the result is loaded into the
// output register, even while that result still waits for m_axis_tready.
// a stalled receiver holds the result; the block then waits with the next
// finished result until the output register is free.
// reset (synchronous, active low) empties all masks and selects no thread;
// tick counters need no clearing since only counts of delayed threads are used.
module priority_scheduler_with_delays_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] delay_ticks, [21:16] thread_prio, [23:22] zero
    input  logic [psd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] req_type
    input  logic [psd_pkg::TYPE_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [5:0] next_prio, [6] switch_request, [8:7] status, [15:9] zero
    output logic [psd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import psd_pkg::*;

    t_dp_cmd            cmd;
    t_dp_stat           stat;
    logic [PRIO_W-1:0]  next_prio;
    logic               switch_request;
    logic [STAT_W-1:0]  status;

    psd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (t_req'(s_axis_tuser)),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    psd_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (s_axis_tuser),
        .i_delay_ticks    (s_axis_tdata[DELAY_W-1:0]),
        .i_thread_prio    (s_axis_tdata[DELAY_W+PRIO_W-1:DELAY_W]),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_next_prio      (next_prio),
        .o_switch_request (switch_request),
        .o_status         (status)
    );

    assign m_axis_tdata = {(OUT_DATA_W - PRIO_W - 1 - STAT_W)'(0),
                           status, switch_request, next_prio};

endmodule

// ===== hdl/psd_checker.sv =====
// port-level checks of the priority scheduler, bound to the top level
`include "assert_macros.svh"

module psd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [psd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import psd_pkg::*;

    `PSD_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "request accepted while previous one still in work")
    `PSD_NEVER(a_prio_range, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tdata[PRIO_W-1:0] > PRIO_W'(NUM_PRIOS)), "next priority beyond priority range")
    `PSD_NEVER(a_reject_no_switch, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[PRIO_W] && (m_axis_tdata[PRIO_W+STAT_W:PRIO_W+1] != ST_OK), "switch raised on rejected request")
    `PSD_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

endmodule

bind priority_scheduler_with_delays_core psd_checker u_psd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
